/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, character codes, register indexes and cell constants for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int CLR_W  = 4;
   localparam int CELL_W = 16;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [CHAR_W-1:0] CODE_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

   localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

   localparam logic [CLR_W-1:0] FG_RESET = 4'h7;
   localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

   localparam logic REG_FG_COLOR = 1'b0;
   localparam logic REG_BG_COLOR = 1'b1;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

endpackage

/* sv/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Single write port, single read port screen store. Read data is registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console with a cursor, a screen store addressed through a
// rotating top-row pointer, and a cell read-back path.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready   tdata: char_code, read_row, read_col
//                                      tuser: mode
// rsp      out  rsp_tvalid/rsp_tready   tdata: cursor_row, cursor_col,
//                                      read_cell, scrolled, wrote_cell
// csr      in   csr_we                  csr_addr, csr_wdata
//
// A character beat is handled in the idle state; a cell read passes through the
// read state while the screen store returns its registered cell.
// A scroll clears the new bottom row in the scroll state, one store write per
// cell of that row.
// After reset the whole store is swept with CELL_RESET while req_tready is
// held low.
// One result is held; a new beat is taken while that result is being taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   // char_code [7:0], read_row [12:8], read_col [19:13], zero fill [23:20]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cursor_row [4:0], cursor_col [11:5], read_cell [27:12], scrolled [28],
   // wrote_cell [29], zero fill [31:30]
   output logic [tcw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [tcw_pkg::CLR_W-1:0]         csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  NUM_COLS = COL_W'(SCREEN_COLS);
   localparam logic [ROW_W:0]    NUM_ROWS = (ROW_W + 1)'(SCREEN_ROWS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_SPAN = ADDR_W'(SCREEN_COLS - 1);

   localparam logic [1:0] ST_INIT   = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_SCROLL = 2'd3;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
      logic [ROW_W:0] sum;
      sum = {1'b0, r} + {1'b0, t};
      if (sum >= NUM_ROWS) begin
         sum = sum - NUM_ROWS;
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(int'(r) * SCREEN_COLS + int'(c));
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [CLR_W-1:0]  fg_ff, fg_in;
   logic [CLR_W-1:0]  bg_ff, bg_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] clr_end_ff, clr_end_in;
   logic [CELL_W-1:0] clr_data_ff, clr_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic              rsp_wrote_ff, rsp_wrote_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              accept;
   logic              in_mode;
   logic [CHAR_W-1:0] in_char;
   logic [ROW_W-1:0]  in_row;
   logic [COL_W-1:0]  in_col;
   logic              is_nl;
   logic              is_cr;
   logic              is_print;
   logic              need_lf;
   logic              do_scroll;
   logic              in_range;
   logic [ROW_W-1:0]  row_lf;
   logic [ROW_W-1:0]  top_lf;
   logic [COL_W-1:0]  col_lf;
   logic [ROW_W-1:0]  cur_phys;
   logic [ADDR_W-1:0] row_base;
   logic [CELL_W-1:0] colour;

   assign in_mode = req_tuser;
   assign in_char = req_tdata[7:0];
   assign in_row  = req_tdata[12:8];
   assign in_col  = req_tdata[19:13];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_nl    = (in_char == CODE_NEWLINE);
   assign is_cr    = (in_char == CODE_RETURN);
   assign is_print = !is_nl && !is_cr && (in_char != CODE_NUL);
   assign need_lf  = is_nl || (is_print && (col_ff >= NUM_COLS));
   assign do_scroll = need_lf && (row_ff == LAST_ROW);
   assign row_lf   = (need_lf && !do_scroll) ? row_ff + 1'b1 : row_ff;
   assign top_lf   = do_scroll ? ((top_ff == LAST_ROW) ? '0 : top_ff + 1'b1) : top_ff;
   assign col_lf   = need_lf ? '0 : col_ff;
   assign cur_phys = phys_row(row_lf, top_lf);
   assign row_base = cell_addr(cur_phys, '0);
   assign colour   = {bg_ff, fg_ff, CODE_NUL};
   assign in_range = (in_row < ROW_W'(SCREEN_ROWS)) && (in_col < NUM_COLS);

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      top_in          = top_ff;
      fg_in           = fg_ff;
      bg_in           = bg_ff;
      clr_addr_in     = clr_addr_ff;
      clr_end_in      = clr_end_ff;
      clr_data_in     = clr_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_wrote_in    = rsp_wrote_ff;
      wr_en           = 1'b0;
      wr_addr         = clr_addr_ff;
      wr_data         = clr_data_ff;
      rd_en           = 1'b0;
      rd_addr         = cell_addr(phys_row(in_row, top_ff), in_col);

      if (csr_we) begin
         case (csr_addr)
            REG_FG_COLOR: fg_in = csr_wdata;
            REG_BG_COLOR: bg_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_INIT, ST_SCROLL: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == clr_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_cell_in     = rd_data;
            state_in        = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_scrolled_in = 1'b0;
               rsp_wrote_in    = 1'b0;
               rsp_cell_in     = '0;
               rsp_row_in      = row_ff;
               rsp_col_in      = col_ff;
               if (in_mode == MODE_READ) begin
                  if (in_range) begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if (is_print) begin
                     wr_en   = 1'b1;
                     wr_addr = row_base + ADDR_W'(col_lf);
                     wr_data = colour | {{(CELL_W-CHAR_W){1'b0}}, in_char};
                     col_in  = col_lf + 1'b1;
                  end else if (is_nl || is_cr) begin
                     col_in = '0;
                  end
                  if (in_char != CODE_NUL) begin
                     row_in = row_lf;
                     top_in = top_lf;
                  end
                  if (do_scroll) begin
                     clr_data_in = colour | {{(CELL_W-CHAR_W){1'b0}}, CODE_SPACE};
                     clr_end_in  = row_base + ROW_SPAN;
                     clr_addr_in = row_base + (is_print ? ADDR_W'(1) : '0);
                     if (!(is_print && SCREEN_COLS == 1)) begin
                        state_in = ST_SCROLL;
                     end
                  end
                  rsp_row_in      = (in_char != CODE_NUL) ? row_lf : row_ff;
                  rsp_col_in      = col_in;
                  rsp_scrolled_in = do_scroll;
                  rsp_wrote_in    = is_print;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         clr_addr_ff  <= '0;
         clr_end_ff   <= LAST_CELL;
         clr_data_ff  <= CELL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         clr_addr_ff  <= clr_addr_in;
         clr_end_ff   <= clr_end_in;
         clr_data_ff  <= clr_data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_wrote_ff    <= rsp_wrote_in;
   end

   tcw_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_wrote_ff, rsp_scrolled_ff, rsp_cell_ff,
                        rsp_col_ff, rsp_row_ff};

endmodule

/* sv/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import tcw_pkg::*;

   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic [CELL_W-1:0] out_cell;
   logic              out_scrolled;
   logic              out_wrote;

   assign out_row      = rsp_tdata[4:0];
   assign out_col      = rsp_tdata[11:5];
   assign out_cell     = rsp_tdata[27:12];
   assign out_scrolled = rsp_tdata[28];
   assign out_wrote    = rsp_tdata[29];

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("Console is not quiet right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result beat changed.");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_scrolled |->
         out_row == ROW_W'(SCREEN_ROWS - 1) && out_col <= COL_W'(1))
      else $error("Scroll reported away from the start of the last row.");

   a_read_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_cell != '0 |-> !out_scrolled && !out_wrote)
      else $error("Read-back result carries write flags.");

   a_wrote_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_wrote |->
         out_col != '0 && out_col <= COL_W'(SCREEN_COLS) &&
         out_row <= ROW_W'(SCREEN_ROWS - 1))
      else $error("Stored character left the cursor out of range.");

endmodule

bind text_console_writer tcw_checker #(
   .SCREEN_COLS (SCREEN_COLS),
   .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console writer. A shadow screen, cursor and
// color pair are updated for every accepted request beat; each response beat
// is compared field by field against the oldest predicted response. The
// run covers reset contents, control codes, out-of-screen reads, line wrap,
// scrolling, color settings, random idling on both sides and a long response
// stall.
// ----------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = SCREEN_COLS + 8;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] read_value;
      logic              scrolled;
      logic              wrote;
   } cursor_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic                  csr_addr = 1'b0;
   logic [CLR_W-1:0]      csr_wdata = '0;

   logic [CELL_W-1:0] screen_shadow [CELLS];
   logic [ROW_W-1:0]  shadow_row;
   logic [COL_W-1:0]  shadow_col;
   logic [CLR_W-1:0]  shadow_fg;
   logic [CLR_W-1:0]  shadow_bg;

   cursor_report_type expected_reports [$];

   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned fail_count = 0;
   int unsigned beats_counted = 0;
   int unsigned reads_sent = 0;
   int unsigned cells_written = 0;
   int unsigned scroll_count = 0;
   int unsigned color_settings = 0;

   text_console_writer #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic next_line();
      logic scrolled;
      scrolled = 1'b0;
      if (int'(shadow_row) + 1 < SCREEN_ROWS) begin
         shadow_row++;
      end else begin
         for (int i = 0; i + SCREEN_COLS < CELLS; i++)
            screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
         for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
            screen_shadow[i] = {shadow_bg, shadow_fg, CODE_SPACE};
         scrolled = 1'b1;
      end
      shadow_col = '0;
      return scrolled;
   endfunction

   function automatic cursor_report_type console_step(input logic mode,
                                                      input logic [CHAR_W-1:0] code,
                                                      input logic [ROW_W-1:0] rrow,
                                                      input logic [COL_W-1:0] rcol);
      cursor_report_type r;
      r = '0;
      if (mode == MODE_READ) begin
         if (rrow < SCREEN_ROWS && rcol < SCREEN_COLS)
            r.read_value = screen_shadow[rrow * SCREEN_COLS + rcol];
         reads_sent++;
      end else if (code == CODE_NEWLINE) begin
         r.scrolled = next_line();
      end else if (code == CODE_RETURN) begin
         shadow_col = '0;
      end else if (code != CODE_NUL) begin
         if (shadow_col >= SCREEN_COLS)
            r.scrolled = next_line();
         screen_shadow[shadow_row * SCREEN_COLS + shadow_col] = {shadow_bg, shadow_fg, code};
         shadow_col++;
         r.wrote = 1'b1;
         cells_written++;
      end
      if (r.scrolled)
         scroll_count++;
      r.row = shadow_row;
      r.col = shadow_col;
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] random_glyph();
      logic [CHAR_W-1:0] g;
      do
         g = CHAR_W'($urandom_range(1, 255));
      while (g == CODE_NEWLINE || g == CODE_RETURN);
      return g;
   endfunction

   task automatic send_beat(input logic mode, input logic [CHAR_W-1:0] code,
                            input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, rcol, rrow, code};
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(console_step(mode, code, rrow, rcol));
      if (mode == MODE_READ || code != CODE_NUL)
         beats_counted++;
   endtask

   task automatic type_char(input logic [CHAR_W-1:0] code);
      send_beat(MODE_WRITE, code, ROW_W'($urandom_range(0, 31)),
                COL_W'($urandom_range(0, 127)));
   endtask

   task automatic peek_cell(input int unsigned rrow, input int unsigned rcol);
      send_beat(MODE_READ, CHAR_W'($urandom_range(0, 255)), ROW_W'(rrow), COL_W'(rcol));
   endtask

   task automatic peek_random();
      case ($urandom_range(0, 3))
         0: begin
            peek_cell(shadow_row, $urandom_range(0, SCREEN_COLS - 1));
         end
         3: begin
            peek_cell($urandom_range(0, 31), $urandom_range(0, 127));
         end
         default: begin
            peek_cell($urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, SCREEN_COLS - 1));
         end
      endcase
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_colors(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= REG_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_addr  <= REG_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_fg = fg;
      shadow_bg = bg;
      color_settings++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("cursor_row", want.row, rsp_tdata[4:0]);
            check_field("cursor_col", want.col, rsp_tdata[11:5]);
            check_field("read_cell", want.read_value, rsp_tdata[27:12]);
            check_field("scrolled", want.scrolled, rsp_tdata[28]);
            check_field("wrote_cell", want.wrote, rsp_tdata[29]);
         end
      end
   end

   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic test_reset_screen_and_codes();
      peek_cell(0, 0);
      peek_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
      peek_cell(SCREEN_ROWS, 0);
      peek_cell(0, SCREEN_COLS);
      peek_cell(31, 127);
      type_char(8'h48);
      type_char(CODE_NUL);
      type_char(8'hFF);
      type_char(8'h01);
      type_char(CODE_SPACE);
      peek_cell(0, 0);
      peek_cell(0, 1);
      peek_cell(0, 3);
      type_char(CODE_RETURN);
      type_char(8'h7E);
      peek_cell(0, 0);
      type_char(CODE_NEWLINE);
      type_char(CODE_NEWLINE);
      type_char(8'h80);
      peek_cell(2, 0);
      type_char(CODE_RETURN);
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 60; i++) begin
         if (i % 4 == 3)
            peek_random();
         else
            type_char(random_glyph());
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_text(input int unsigned beats);
      int unsigned goal;
      int unsigned len;
      int unsigned pick;
      goal = beats_counted + beats;
      while (beats_counted < goal) begin
         if ($urandom_range(0, 19) == 0)
            idle_on = !idle_on;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(75, 170) : $urandom_range(0, 40);
         for (int i = 0; i < len && beats_counted < goal; i++) begin
            pick = $urandom_range(0, 39);
            if (pick < 5)
               peek_random();
            else if (pick == 5)
               type_char(CODE_NUL);
            else if (pick == 6)
               type_char(CODE_RETURN);
            else
               type_char(random_glyph());
         end
         if ($urandom_range(0, 9) != 0)
            type_char(CODE_NEWLINE);
      end
   endtask

   task automatic test_color_phases();
      set_colors(4'h0, 4'h0);
      test_random_text(330);
      set_colors(4'hF, 4'hF);
      test_random_text(330);
      set_colors(4'hF, 4'h0);
      test_random_text(330);
      set_colors(CLR_W'($urandom_range(0, 15)), CLR_W'($urandom_range(0, 15)));
      test_random_text(330);
      set_colors(4'h0, 4'hF);
      test_random_text(330);
   endtask

   initial begin
      foreach (screen_shadow[i])
         screen_shadow[i] = CELL_RESET;
      shadow_row = '0;
      shadow_col = '0;
      shadow_fg  = FG_RESET;
      shadow_bg  = BG_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_screen_and_codes();
      test_output_backpressure();
      test_color_phases();

      wait_idle();
      $display("Covered %0d beats: %0d cell writes, %0d cell reads, %0d scrolls.",
               beats_counted, cells_written, reads_sent, scroll_count);
      $display("Used %0d color settings and one long response stall.", color_settings);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d responses outstanding.", expected_reports.size());
      $display("tb NOT OK");
      $finish;
   end

endmodule

/* sim.f */
sv/tcw_pkg.sv
sv/tcw_screen_ram.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
test/tb.sv
